[rtl/iqrf_pkg.sv]
// shared types, codes and defaults for the inverse quadratic root finder
`timescale 1ns / 1ps
package iqrf_pkg;

  localparam int unsigned WORD_BITS_DEF     = 32;
  localparam int unsigned FRACTION_BITS_DEF = 16;

  localparam logic [6:0]  MAX_ITER        = 7'd64;
  localparam logic [6:0]  ITER_LIMIT_RST  = 7'd20;
  localparam logic [30:0] TOLERANCE_RST   = 31'd66;

  typedef enum logic [2:0] {
    ST_CONT       = 3'd0,
    ST_TOL        = 3'd1,
    ST_EXACT      = 3'd2,
    ST_LIMIT      = 3'd3,
    ST_START_ROOT = 3'd4,
    ST_FAULT      = 3'd5
  } status_e;

  typedef struct packed {
    logic signed [31:0] start_a;
    logic signed [31:0] start_b;
    logic signed [31:0] start_c;
  } in_word_t;

  typedef struct packed {
    logic [6:0]         iteration;
    logic signed [31:0] estimate;
    logic signed [31:0] residual;
    logic [30:0]        step_size;
    status_e            status;
    logic               last;
  } out_word_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    U_IDLE = 2'd0,
    U_RUN  = 2'd1,
    U_FIN1 = 2'd2,
    U_FIN2 = 2'd3
  } unit_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } unit_req_t;

  typedef struct packed {
    logic done;
    logic fault;
  } unit_rsp_t;

  typedef enum logic [1:0] {
    FN_A = 2'd0,
    FN_B = 2'd1,
    FN_C = 2'd2,
    FN_D = 2'd3
  } fn_e;

  typedef enum logic [4:0] {
    S_IDLE, S_FN_MUL, S_FN_SUB1, S_FN_SUB2, S_FN_STORE, S_CHECK, S_IT_BEGIN,
    S_IT_U, S_IT_V, S_IT_W, S_IT_S1, S_IT_M1, S_IT_S2, S_IT_M2, S_IT_S3,
    S_IT_S4, S_IT_M3, S_IT_T, S_IT_P, S_IT_S5, S_IT_S6, S_IT_M4, S_IT_S7,
    S_IT_Q, S_IT_R, S_IT_D, S_IT_E, S_IT_ABS, S_FAULT, S_STATUS, S_EMIT,
    S_SHIFT
  } ctrl_e;

endpackage

[rtl/iqrf_serial_unit.sv]
// bit-serial signed fixed point multiplier and divider, one bit per cycle
`timescale 1ns / 1ps
module iqrf_serial_unit #(
  parameter int unsigned W = iqrf_pkg::WORD_BITS_DEF,
  parameter int unsigned F = iqrf_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iqrf_pkg::unit_req_t req_i,
  input  logic [W-1:0]        opa_i,
  input  logic [W-1:0]        opb_i,
  output iqrf_pkg::unit_rsp_t rsp_o,
  output logic [W-1:0]        res_o
);
  import iqrf_pkg::*;

  localparam int unsigned NW = W + F;
  localparam int unsigned PW = 2 * W - F + 1;
  localparam int unsigned MW = (PW > NW) ? PW : NW;
  localparam int unsigned CW = $clog2(NW + 1);

  unit_e state_q, state_d;
  op_e             op_q;
  logic            neg_q;
  logic            dz_q;
  logic [CW-1:0]   cnt_q;
  logic [W-1:0]    x_q;
  logic [2*W-1:0]  acc_q;
  logic [NW-1:0]   num_q;
  logic [W-1:0]    rem_q;
  logic [MW-1:0]   mag_q;

  logic [W-1:0]    mag_a, mag_b;
  logic [W:0]      mul_sum;
  logic [2*W-1:0]  acc_step;
  logic [W:0]      div_rt, div_sub;
  logic            div_ge;
  logic [W-1:0]    rem_step;
  logic [NW-1:0]   num_step;
  logic [PW-1:0]   mul_mag;
  logic [MW-1:0]   fin_mag;
  logic [MW-1:0]   lim;

  assign mag_a = opa_i[W-1] ? (~opa_i + W'(1)) : opa_i;
  assign mag_b = opb_i[W-1] ? (~opb_i + W'(1)) : opb_i;

  // shift-add step
  assign mul_sum  = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, x_q} : '0);
  assign acc_step = {mul_sum, acc_q[W-1:1]};

  // restoring division step
  assign div_rt   = {rem_q, num_q[NW-1]};
  assign div_ge   = div_rt >= {1'b0, x_q};
  assign div_sub  = div_rt - {1'b0, x_q};
  assign rem_step = div_ge ? div_sub[W-1:0] : div_rt[W-1:0];
  assign num_step = {num_q[NW-2:0], div_ge};

  // drop fraction bits, round toward minus infinity on negative products
  assign mul_mag = {1'b0, acc_q[2*W-1:F]} + PW'(neg_q & (|acc_q[F-1:0]));
  assign fin_mag = (op_q == OP_MUL) ? MW'(mul_mag) : MW'(num_q);
  assign lim     = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}} + MW'(neg_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          state_d = (req_i.op == OP_DIV && opb_i == '0) ? U_FIN2 : U_RUN;
        end
      end
      U_RUN: begin
        if (cnt_q == CW'(1)) begin
          state_d = U_FIN1;
        end
      end
      U_FIN1:  state_d = U_FIN2;
      U_FIN2:  state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done  = (state_q == U_FIN2);
    rsp_o.fault = dz_q | (mag_q > lim);
    res_o       = neg_q ? (~mag_q[W-1:0] + W'(1)) : mag_q[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      dz_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == U_IDLE && req_i.start) begin
        dz_q <= (req_i.op == OP_DIV) && (opb_i == '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          op_q  <= req_i.op;
          neg_q <= opa_i[W-1] ^ opb_i[W-1];
          x_q   <= (req_i.op == OP_MUL) ? mag_a : mag_b;
          acc_q <= {{W{1'b0}}, mag_b};
          num_q <= {mag_a, {F{1'b0}}};
          rem_q <= '0;
          cnt_q <= (req_i.op == OP_MUL) ? CW'(W) : CW'(NW);
        end
      end
      U_RUN: begin
        if (op_q == OP_MUL) begin
          acc_q <= acc_step;
        end else begin
          num_q <= num_step;
          rem_q <= rem_step;
        end
        cnt_q <= cnt_q - CW'(1);
      end
      U_FIN1: mag_q <= fin_mag;
      default: ;
    endcase
  end

endmodule

[rtl/inverse_quadratic_root_finder.sv]
// inverse quadratic interpolation root finder for x*x - x - 2, fixed point
// sequencing: start point evaluations and each iteration run their multiplies and
//   divides one at a time through the one shared bit-serial multiply/divide unit
// throughput: one run at a time, a new word is taken once the last result is queued
// reset: asynchronous active low, clears control state, limit 20, tolerance 66
`timescale 1ns / 1ps
module inverse_quadratic_root_finder #(
  parameter int unsigned WORD_BITS     = iqrf_pkg::WORD_BITS_DEF,
  parameter int unsigned FRACTION_BITS = iqrf_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input words: three start points
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  iqrf_pkg::in_word_t  in_word_i,
  // result words
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output iqrf_pkg::out_word_t out_word_o,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import iqrf_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned F  = FRACTION_BITS;
  localparam int unsigned EW = (W > 32) ? W : 32;

  localparam logic [W-1:0] WMAX_C = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN_C = {1'b1, {(W-1){1'b0}}};
  // fixed point 1.0 and 2.0, clipped to the word range
  localparam logic [W-1:0] ONE_C  = (F <= W - 2) ? (W'(1) << F) : WMAX_C;
  localparam logic [W-1:0] TWO_C  = (F + 1 <= W - 2) ? (W'(2) << F) : WMAX_C;

  // register index is address bit 2
  localparam logic REG_LIMIT = 1'b0;
  localparam logic REG_TOL   = 1'b1;

  // sign extend a 32 bit input and clamp it into the word
  function automatic logic [W-1:0] load_word(input logic [31:0] v);
    logic [EW-1:0] x, hi, lo;
    x  = EW'($signed(v));
    hi = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    lo = ~hi;
    if ($signed(x) > $signed(hi)) begin
      x = hi;
    end else if ($signed(x) < $signed(lo)) begin
      x = lo;
    end
    return x[W-1:0];
  endfunction

  // saturate a word to 32 bits signed
  function automatic logic [31:0] sat32(input logic [W-1:0] v);
    logic [EW-1:0] x, hi, lo;
    x  = EW'($signed(v));
    hi = EW'(32'h7fff_ffff);
    lo = ~hi;
    if ($signed(x) > $signed(hi)) begin
      x = hi;
    end else if ($signed(x) < $signed(lo)) begin
      x = lo;
    end
    return x[31:0];
  endfunction

  // saturate a non-negative step to 31 bits
  function automatic logic [30:0] sat_step(input logic [W-1:0] v);
    logic [EW-1:0] x;
    x = EW'(v);
    if (x > EW'(31'h7fff_ffff)) begin
      return 31'h7fff_ffff;
    end
    return x[30:0];
  endfunction

  // configuration registers
  logic [6:0]  iter_limit_q;
  logic [30:0] tolerance_q;
  logic        cfg_wr;

  // sequencer control
  ctrl_e state_q, state_d;
  logic        issued_q;
  fn_e         fn_q;
  logic [6:0]  iter_q;
  logic [6:0]  limit_q;
  logic [6:0]  limit_clamped;

  // working registers: points, function values, ratios, temporaries
  logic [W-1:0] pa_q, pb_q, pc_q, pd_q;
  logic [W-1:0] fa_q, fb_q, fc_q, fd_q;
  logic         sa_q, sb_q, sc_q, sd_q, fsat_q;
  logic [W-1:0] u_q, v_q, w_q;
  logic [W-1:0] t0_q, t1_q, t2_q;
  logic [W-1:0] e_q;
  logic [W-1:0] fx_q;
  out_word_t    res_q;

  // output register
  logic         out_valid_q;
  out_word_t    out_q;
  logic         out_free;

  // shared adder
  logic [W-1:0] alu_a, alu_b;
  logic         alu_sub;
  logic [W:0]   alu_sum;
  logic         alu_ovf;
  logic [W-1:0] alu_sat;

  // serial unit
  unit_req_t    u_req;
  unit_rsp_t    u_rsp;
  logic [W-1:0] u_a, u_b;
  logic [W-1:0] u_res;
  logic         unit_state;
  logic         u_ok;
  logic         u_bad;

  logic [W-1:0] fn_arg;
  logic         in_accept;
  logic         tol_met;
  status_e      it_status;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[2])
      REG_LIMIT: prdata = {25'd0, iter_limit_q};
      REG_TOL:   prdata = {1'b0, tolerance_q};
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_limit_q <= ITER_LIMIT_RST;
      tolerance_q  <= TOLERANCE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LIMIT: iter_limit_q <= pwdata[6:0];
        REG_TOL:   tolerance_q  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // limit of 0 acts as 1, anything above the maximum acts as the maximum
  always_comb begin
    if (iter_limit_q == 7'd0) begin
      limit_clamped = 7'd1;
    end else if (iter_limit_q > MAX_ITER) begin
      limit_clamped = MAX_ITER;
    end else begin
      limit_clamped = iter_limit_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  // argument of the function evaluation in flight
  always_comb begin
    case (fn_q)
      FN_A:    fn_arg = pa_q;
      FN_B:    fn_arg = pb_q;
      FN_C:    fn_arg = pc_q;
      FN_D:    fn_arg = pd_q;
      default: fn_arg = pa_q;
    endcase
  end

  // checked add/subtract with overflow and saturation value
  assign alu_sum = alu_sub ? ({alu_a[W-1], alu_a} - {alu_b[W-1], alu_b})
                           : ({alu_a[W-1], alu_a} + {alu_b[W-1], alu_b});
  assign alu_ovf = alu_sum[W] ^ alu_sum[W-1];
  assign alu_sat = alu_sum[W] ? WMIN_C : WMAX_C;

  assign unit_state = state_q inside {S_FN_MUL, S_IT_U, S_IT_V, S_IT_W, S_IT_M1,
                                      S_IT_M2, S_IT_M3, S_IT_P, S_IT_M4, S_IT_Q,
                                      S_IT_R};
  assign u_ok  = u_rsp.done & ~u_rsp.fault;
  assign u_bad = u_rsp.done & u_rsp.fault;

  // operand routing for the adder and the serial unit
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    u_a     = '0;
    u_b     = '0;
    u_req.op    = OP_MUL;
    u_req.start = unit_state & ~issued_q;
    case (state_q)
      S_FN_MUL:  begin u_a = fn_arg; u_b = fn_arg; end
      S_FN_SUB1: begin alu_a = fx_q; alu_b = fn_arg; end
      S_FN_SUB2: begin alu_a = fx_q; alu_b = TWO_C; end
      S_IT_U:    begin u_req.op = OP_DIV; u_a = fb_q; u_b = fc_q; end
      S_IT_V:    begin u_req.op = OP_DIV; u_a = fb_q; u_b = fa_q; end
      S_IT_W:    begin u_req.op = OP_DIV; u_a = fa_q; u_b = fc_q; end
      S_IT_S1:   begin alu_a = u_q; alu_b = w_q; end
      S_IT_M1:   begin u_a = w_q; u_b = t0_q; end
      S_IT_S2:   begin alu_a = pc_q; alu_b = pb_q; end
      S_IT_M2:   begin u_a = t0_q; u_b = t1_q; end
      S_IT_S3:   begin alu_a = ONE_C; alu_b = u_q; end
      S_IT_S4:   begin alu_a = pb_q; alu_b = pa_q; end
      S_IT_M3:   begin u_a = t1_q; u_b = t2_q; end
      S_IT_T:    begin alu_a = t0_q; alu_b = t1_q; end
      S_IT_P:    begin u_a = v_q; u_b = t0_q; end
      S_IT_S5:   begin alu_a = w_q; alu_b = ONE_C; end
      S_IT_S6:   begin alu_a = v_q; alu_b = ONE_C; end
      S_IT_M4:   begin u_a = t1_q; u_b = t2_q; end
      S_IT_S7:   begin alu_a = u_q; alu_b = ONE_C; end
      S_IT_Q:    begin u_a = t1_q; u_b = t2_q; end
      S_IT_R:    begin u_req.op = OP_DIV; u_a = t0_q; u_b = t1_q; end
      S_IT_D:    begin alu_a = pb_q; alu_b = t0_q; alu_sub = 1'b0; end
      S_IT_E:    begin alu_a = pd_q; alu_b = pb_q; end
      S_IT_ABS:  begin alu_a = '0; alu_b = e_q; end
      default: ;
    endcase
  end

  iqrf_serial_unit #(
    .W (W),
    .F (F)
  ) u_serial (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (u_req),
    .opa_i  (u_a),
    .opb_i  (u_b),
    .rsp_o  (u_rsp),
    .res_o  (u_res)
  );

  // stop tests for a finished iteration: exact root, then tolerance, then limit
  assign tol_met = EW'(e_q) <= EW'(tolerance_q);
  always_comb begin
    if (fd_q == '0) begin
      it_status = ST_EXACT;
    end else if (tol_met) begin
      it_status = ST_TOL;
    end else if (iter_q >= limit_q) begin
      it_status = ST_LIMIT;
    end else begin
      it_status = ST_CONT;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:     if (in_accept) state_d = S_FN_MUL;
      S_FN_MUL:   if (u_rsp.done) state_d = u_rsp.fault ? S_FN_STORE : S_FN_SUB1;
      S_FN_SUB1:  state_d = alu_ovf ? S_FN_STORE : S_FN_SUB2;
      S_FN_SUB2:  state_d = S_FN_STORE;
      S_FN_STORE: begin
        case (fn_q)
          FN_A, FN_B: state_d = S_FN_MUL;
          FN_C:       state_d = S_CHECK;
          FN_D:       state_d = S_STATUS;
          default:    state_d = S_IDLE;
        endcase
      end
      S_CHECK: begin
        state_d = (fa_q == '0 || fb_q == '0 || fc_q == '0) ? S_EMIT : S_IT_BEGIN;
      end
      // a saturated function value from an earlier evaluation is a fault here
      S_IT_BEGIN: state_d = (sa_q | sb_q | sc_q) ? S_FAULT : S_IT_U;
      S_IT_U:  if (u_bad) state_d = S_FAULT; else if (u_ok) state_d = S_IT_V;
      S_IT_V:  if (u_bad) state_d = S_FAULT; else if (u_ok) state_d = S_IT_W;
      S_IT_W:  if (u_bad) state_d = S_FAULT; else if (u_ok) state_d = S_IT_S1;
      S_IT_S1: state_d = alu_ovf ? S_FAULT : S_IT_M1;
      S_IT_M1: if (u_bad) state_d = S_FAULT; else if (u_ok) state_d = S_IT_S2;
      S_IT_S2: state_d = alu_ovf ? S_FAULT : S_IT_M2;
      S_IT_M2: if (u_bad) state_d = S_FAULT; else if (u_ok) state_d = S_IT_S3;
      S_IT_S3: state_d = alu_ovf ? S_FAULT : S_IT_S4;
      S_IT_S4: state_d = alu_ovf ? S_FAULT : S_IT_M3;
      S_IT_M3: if (u_bad) state_d = S_FAULT; else if (u_ok) state_d = S_IT_T;
      S_IT_T:  state_d = alu_ovf ? S_FAULT : S_IT_P;
      S_IT_P:  if (u_bad) state_d = S_FAULT; else if (u_ok) state_d = S_IT_S5;
      S_IT_S5: state_d = alu_ovf ? S_FAULT : S_IT_S6;
      S_IT_S6: state_d = alu_ovf ? S_FAULT : S_IT_M4;
      S_IT_M4: if (u_bad) state_d = S_FAULT; else if (u_ok) state_d = S_IT_S7;
      S_IT_S7: state_d = alu_ovf ? S_FAULT : S_IT_Q;
      S_IT_Q:  if (u_bad) state_d = S_FAULT; else if (u_ok) state_d = S_IT_R;
      S_IT_R:  if (u_bad) state_d = S_FAULT; else if (u_ok) state_d = S_IT_D;
      S_IT_D:  state_d = alu_ovf ? S_FAULT : S_IT_E;
      S_IT_E:  state_d = alu_ovf ? S_FAULT : S_IT_ABS;
      S_IT_ABS: state_d = (e_q[W-1] & alu_ovf) ? S_FAULT : S_FN_MUL;
      S_FAULT:  state_d = S_EMIT;
      S_STATUS: state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d = res_q.last ? S_IDLE : S_SHIFT;
        end
      end
      S_SHIFT: state_d = S_IT_BEGIN;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      fn_q        <= FN_A;
      iter_q      <= '0;
      limit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (u_req.start) begin
        issued_q <= 1'b1;
      end else if (u_rsp.done) begin
        issued_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            fn_q    <= FN_A;
            limit_q <= limit_clamped;
          end
        end
        S_FN_STORE: begin
          if (fn_q == FN_A) begin
            fn_q <= FN_B;
          end else if (fn_q == FN_B) begin
            fn_q <= FN_C;
          end
        end
        S_CHECK:  iter_q <= 7'd1;
        S_IT_ABS: fn_q   <= FN_D;
        S_SHIFT:  iter_q <= iter_q + 7'd1;
        default: ;
      endcase

      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          pa_q <= load_word(in_word_i.start_a);
          pb_q <= load_word(in_word_i.start_b);
          pc_q <= load_word(in_word_i.start_c);
        end
      end
      // f(x) = x*x - x - 2, an overflowing square saturates high
      S_FN_MUL: begin
        if (u_rsp.done) begin
          fx_q   <= u_rsp.fault ? WMAX_C : u_res;
          fsat_q <= u_rsp.fault;
        end
      end
      S_FN_SUB1, S_FN_SUB2: begin
        fx_q   <= alu_ovf ? alu_sat : alu_sum[W-1:0];
        fsat_q <= alu_ovf;
      end
      S_FN_STORE: begin
        case (fn_q)
          FN_A:    begin fa_q <= fx_q; sa_q <= fsat_q; end
          FN_B:    begin fb_q <= fx_q; sb_q <= fsat_q; end
          FN_C:    begin fc_q <= fx_q; sc_q <= fsat_q; end
          FN_D:    begin fd_q <= fx_q; sd_q <= fsat_q; end
          default: ;
        endcase
      end
      // start point root: a first, then b, then c
      S_CHECK: begin
        res_q.iteration <= '0;
        res_q.residual  <= '0;
        res_q.step_size <= '0;
        res_q.status    <= ST_START_ROOT;
        res_q.last      <= 1'b1;
        if (fa_q == '0) begin
          res_q.estimate <= sat32(pa_q);
        end else if (fb_q == '0) begin
          res_q.estimate <= sat32(pb_q);
        end else begin
          res_q.estimate <= sat32(pc_q);
        end
      end
      S_IT_U:  if (u_rsp.done) u_q  <= u_res;
      S_IT_V:  if (u_rsp.done) v_q  <= u_res;
      S_IT_W:  if (u_rsp.done) w_q  <= u_res;
      S_IT_S1: t0_q <= alu_sum[W-1:0];
      S_IT_M1: if (u_rsp.done) t0_q <= u_res;
      S_IT_S2: t1_q <= alu_sum[W-1:0];
      S_IT_M2: if (u_rsp.done) t0_q <= u_res;
      S_IT_S3: t1_q <= alu_sum[W-1:0];
      S_IT_S4: t2_q <= alu_sum[W-1:0];
      S_IT_M3: if (u_rsp.done) t1_q <= u_res;
      S_IT_T:  t0_q <= alu_sum[W-1:0];
      S_IT_P:  if (u_rsp.done) t0_q <= u_res;
      S_IT_S5: t1_q <= alu_sum[W-1:0];
      S_IT_S6: t2_q <= alu_sum[W-1:0];
      S_IT_M4: if (u_rsp.done) t1_q <= u_res;
      S_IT_S7: t2_q <= alu_sum[W-1:0];
      S_IT_Q:  if (u_rsp.done) t1_q <= u_res;
      S_IT_R:  if (u_rsp.done) t0_q <= u_res;
      S_IT_D:  pd_q <= alu_sum[W-1:0];
      S_IT_E:  e_q  <= alu_sum[W-1:0];
      S_IT_ABS: begin
        if (e_q[W-1]) begin
          e_q <= alu_sum[W-1:0];
        end
      end
      S_FAULT: begin
        res_q.iteration <= iter_q;
        res_q.estimate  <= '0;
        res_q.residual  <= '0;
        res_q.step_size <= '0;
        res_q.status    <= ST_FAULT;
        res_q.last      <= 1'b1;
      end
      S_STATUS: begin
        res_q.iteration <= iter_q;
        res_q.estimate  <= sat32(pd_q);
        res_q.residual  <= sat32(fd_q);
        res_q.step_size <= sat_step(e_q);
        res_q.status    <= it_status;
        res_q.last      <= (it_status != ST_CONT);
      end
      // a <- b, b <- c, c <- d, with their function values carried along
      S_SHIFT: begin
        pa_q <= pb_q;
        pb_q <= pc_q;
        pc_q <= pd_q;
        fa_q <= fb_q;
        fb_q <= fc_q;
        fc_q <= fd_q;
        sa_q <= sb_q;
        sb_q <= sc_q;
        sc_q <= sd_q;
      end
      default: ;
    endcase

    if (state_q == S_EMIT && out_free) begin
      out_q <= res_q;
    end
  end

endmodule

[tb/inverse_quadratic_root_finder_test.sv]
// self-checking testbench for the inverse quadratic root finder
`timescale 1ns / 1ps
module inverse_quadratic_root_finder_test;
  import iqrf_pkg::*;

  localparam longint WMAX = 64'sd2147483647;
  localparam longint WMIN = -64'sd2147483648;
  localparam longint ONE_FX = 64'sd65536;
  localparam longint TWO_FX = 64'sd131072;
  localparam int REG_LIMIT = 0;
  localparam int REG_TOL = 1;
  localparam int STALL_LIMIT = 100000;
  localparam int HOLD_CYCLES = 3000;
  localparam int N_DIRECTED = 14;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  inverse_quadratic_root_finder uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor copy of the two registers
  logic [6:0]  limit_reg = ITER_LIMIT_RST;
  logic [30:0] tol_reg = TOLERANCE_RST;

  out_word_t result_q[$];  // results still owed by the block
  int        mism = 0;
  bit        quiet = 1'b0;   // no idling on either side while set
  bit        hold_req = 1'b0;
  bit        ovf;            // divide-by-zero or overflow inside an iteration

  // ---------------------------------------------------------------- arithmetic
  function automatic longint fit(longint x);
    if (x > WMAX || x < WMIN) begin
      ovf = 1'b1;
      return 0;
    end
    return x;
  endfunction

  // product rounded toward minus infinity
  function automatic longint fmul(longint a, longint b);
    return fit((a * b) >>> 16);
  endfunction

  // quotient truncated toward zero
  function automatic longint fdiv(longint a, longint b);
    if (b == 0) begin
      ovf = 1'b1;
      return 0;
    end
    return fit((a <<< 16) / b);
  endfunction

  function automatic longint sat_word(longint x, inout bit sat);
    if (x > WMAX) begin
      sat = 1'b1;
      return WMAX;
    end
    if (x < WMIN) begin
      sat = 1'b1;
      return WMIN;
    end
    return x;
  endfunction

  // x*x - x - 2, each stage saturated, sat set when any stage clips
  function automatic longint poly(longint x, output bit sat);
    longint sq;
    longint r;
    sat = 1'b0;
    sq = (x * x) >>> 16;
    if (sq > WMAX) begin
      sat = 1'b1;
      return WMAX;
    end
    r = sat_word(sq - x, sat);
    if (sat) return r;
    return sat_word(r - TWO_FX, sat);
  endfunction

  // ---------------------------------------------------------------- predictor
  task automatic predict_run(in_word_t w);
    longint a, b, c, d, fa, fb, fc, fd, u, v, x, t, p, q, e;
    bit s1, s2, s3, sd;
    int lim;
    out_word_t r;
    a = longint'(w.start_a);
    b = longint'(w.start_b);
    c = longint'(w.start_c);
    d = 0;
    lim = int'(limit_reg);
    if (lim < 1) lim = 1;
    if (lim > 64) lim = 64;
    fa = poly(a, s1);
    fb = poly(b, s2);
    fc = poly(c, s3);
    if (fa == 0 || fb == 0 || fc == 0) begin
      r = '0;
      r.estimate = 32'((fa == 0) ? a : ((fb == 0) ? b : c));
      r.status = ST_START_ROOT;
      r.last = 1'b1;
      result_q.push_back(r);
      return;
    end
    for (int i = 1; i <= lim; i++) begin
      if (i > 1) begin
        a = b;
        b = c;
        c = d;
      end
      ovf = 1'b0;
      fa = poly(a, s1);
      fb = poly(b, s2);
      fc = poly(c, s3);
      if (s1 || s2 || s3) ovf = 1'b1;
      u = fdiv(fb, fc);
      v = fdiv(fb, fa);
      x = fdiv(fa, fc);
      t = fmul(fmul(x, fit(u - x)), fit(c - b));
      t = fit(t - fmul(fit(ONE_FX - u), fit(b - a)));
      p = fmul(v, t);
      q = fmul(fmul(fit(x - ONE_FX), fit(v - ONE_FX)), fit(u - ONE_FX));
      d = fit(b + fdiv(p, q));
      e = fit(d - b);
      if (e < 0) e = fit(-e);
      r = '0;
      r.iteration = i[6:0];
      if (ovf) begin
        r.status = ST_FAULT;
        r.last = 1'b1;
        result_q.push_back(r);
        return;
      end
      fd = poly(d, sd);
      r.estimate = d[31:0];
      r.residual = fd[31:0];
      r.step_size = e[30:0];
      if (fd == 0) r.status = ST_EXACT;
      else if (e <= longint'(tol_reg)) r.status = ST_TOL;
      else if (i >= lim) r.status = ST_LIMIT;
      else r.status = ST_CONT;
      r.last = (r.status != ST_CONT);
      result_q.push_back(r);
      if (r.last) return;
    end
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic send_word(in_word_t w);
    while (!quiet && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic reg_write(int idx, logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * idx);
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_LIMIT) limit_reg = val[6:0];
    else tol_reg = val[30:0];
  endtask

  // block idle: every result in, then a short settle
  task automatic drain;
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] fx(real r);
    return 32'($rtoi(r * 65536.0));
  endfunction

  // random start points: mostly close to the roots, some anywhere
  function automatic in_word_t rand_word();
    in_word_t w;
    int sel;
    sel = $urandom_range(99);
    w.start_a = $urandom_range(1048576) - 524288;
    w.start_b = $urandom_range(1048576) - 524288;
    w.start_c = $urandom_range(1048576) - 524288;
    if (sel < 12) begin
      w = {$urandom, $urandom, $urandom};
    end else if (sel < 17) begin
      w.start_b = ($urandom_range(1)) ? 32'sd131072 : -32'sd65536;
    end else if (sel < 22) begin
      w.start_c = w.start_b;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------- checker
  initial begin : receiver
    int hold_left;
    out_word_t exp_w;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          mism++;
          if (mism <= 10) $display("unexpected result word %p", out_word_o);
        end else begin
          exp_w = result_q.pop_front();
          if (out_word_o.iteration !== exp_w.iteration ||
              out_word_o.estimate !== exp_w.estimate ||
              out_word_o.residual !== exp_w.residual ||
              out_word_o.step_size !== exp_w.step_size ||
              out_word_o.status !== exp_w.status ||
              out_word_o.last !== exp_w.last) begin
            mism++;
            if (mism <= 10)
              $display("mismatch: expected %p, got %p", exp_w, out_word_o);
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) hold_left--;
      out_stall_i <= (hold_left > 0) || (!quiet && $urandom_range(99) < 21);
    end
  end

  // watchdog on cycles without any accepted word
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("inverse_quadratic_root_finder regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } row_t;

  row_t rows[N_DIRECTED];

  function automatic out_word_t typed_res(logic [6:0] it, logic [31:0] est, status_e st);
    out_word_t r;
    r = '0;
    r.iteration = it;
    r.estimate = est;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  initial begin : stimulus
    // start roots, a checked before b before c
    rows[0] = '{'{fx(2.0), fx(0.5), fx(3.0)}, 1'b1, typed_res(7'd0, fx(2.0), ST_START_ROOT)};
    rows[1] = '{'{fx(0.5), fx(-1.0), fx(3.0)}, 1'b1, typed_res(7'd0, fx(-1.0), ST_START_ROOT)};
    rows[2] = '{'{fx(0.5), fx(1.5), fx(2.0)}, 1'b1, typed_res(7'd0, fx(2.0), ST_START_ROOT)};
    rows[3] = '{'{fx(-1.0), fx(2.0), fx(5.0)}, 1'b1, typed_res(7'd0, fx(-1.0), ST_START_ROOT)};
    // equal points: zero divisor
    rows[4] = '{'{32'h0, 32'h0, 32'h0}, 1'b1, typed_res(7'd1, 32'd0, ST_FAULT)};
    // extremes: f saturates on a start point, a fault in the first iteration
    rows[5] = '{'{32'h8000_0000, fx(1.0), fx(3.0)}, 1'b1, typed_res(7'd1, 32'd0, ST_FAULT)};
    rows[6] = '{'{fx(1.0), 32'h7fff_ffff, fx(3.0)}, 1'b1, typed_res(7'd1, 32'd0, ST_FAULT)};
    rows[7] = '{'{32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 1'b1,
                typed_res(7'd1, 32'd0, ST_FAULT)};
    rows[8] = '{'{fx(0.0), fx(1.0), fx(3.0)}, 1'b0, '0};
    rows[9] = '{'{fx(1.5), fx(2.5), fx(3.5)}, 1'b0, '0};
    rows[10] = '{'{fx(-3.0), fx(-2.0), fx(-0.5)}, 1'b0, '0};
    rows[11] = '{'{fx(100.0), fx(50.0), fx(10.0)}, 1'b0, '0};
    rows[12] = '{'{32'h0000_0001, 32'hffff_fffe, fx(1.0)}, 1'b0, '0};
    rows[13] = '{'{fx(181.0), fx(-181.0), fx(0.25)}, 1'b0, '0};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows at reset settings
    foreach (rows[k]) begin
      if (rows[k].typed) result_q.push_back(rows[k].res);
      else predict_run(rows[k].w);
      send_word(rows[k].w);
    end
    drain();

    // phases of random words, each under its own register settings
    begin
      int lims[6];
      int tols[6];
      int cnts[6];
      in_word_t w;
      lims = '{0, 64, 5, 127, 12, 20};
      tols = '{0, 0, 2147483647, 1000, 66, 5};
      cnts = '{40, 20, 60, 60, 250, 50};
      for (int ph = 0; ph < 6; ph++) begin
        reg_write(REG_LIMIT, lims[ph]);
        reg_write(REG_TOL, tols[ph]);
        quiet = (ph == 4);
        if (ph == 2) hold_req = 1'b1;  // receiver backs off, input must fill and stall
        for (int n = 0; n < cnts[ph]; n++) begin
          // sender waits once mid-phase until the block has drained
          if (ph == 4 && n == 100) begin
            in_valid_i <= 1'b0;
            while (result_q.size() != 0) @(posedge clk_i);
          end
          w = rand_word();
          predict_run(w);
          send_word(w);
        end
        drain();
      end
    end

    repeat (1000) @(posedge clk_i);
    if (mism == 0 && result_q.size() == 0)
      $display("inverse_quadratic_root_finder regression: pass");
    else
      $display("inverse_quadratic_root_finder regression: fail");
    $finish;
  end

endmodule
